[rtl/core/glcw_pkg.sv]
// ----------------------------------------------------------------------------
// glcw_pkg
// shared types and constants of the grid line cell walk core
// ----------------------------------------------------------------------------
`default_nettype none

package glcw_pkg;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned COLS_W  = 6;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned CNT_W   = 7;

  // most results one segment may produce
  localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;
  localparam logic [COLS_W-1:0] COLS_RESET = 6'd32;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL   = 5'b00010,
    ST_INIT  = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic init;
    logic walk;
    logic flush;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;
    logic capped;
    logic final_step;
  } status_t;

endpackage

`default_nettype wire

[rtl/core/glcw_ctrl.sv]
// ----------------------------------------------------------------------------
// glcw_ctrl
// sequencer: setup, multiply, init, per-square walk, final flush
// ----------------------------------------------------------------------------
`default_nettype none

module glcw_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire glcw_pkg::status_t status_i,
  output glcw_pkg::cmd_t         cmd_o,
  output logic                   busy_o
);

  import glcw_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_INIT;
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_WALK;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.empty || status_i.capped) begin
          state_d = ST_IDLE;
        end else if (status_i.final_step) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

[rtl/core/glcw_datapath.sv]
// ----------------------------------------------------------------------------
// glcw_datapath
// endpoint registers, error term, walk position, cell index and run folding
// ----------------------------------------------------------------------------
`default_nettype none

module glcw_datapath #(
  parameter int unsigned CELL_SHIFT = 3,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned UNIT_BITS  = 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire glcw_pkg::cmd_t                 cmd_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [glcw_pkg::COLS_W-1:0]    cfg_wdata_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]   start_x_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]   start_y_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]   end_x_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]   end_y_i,
  output glcw_pkg::status_t                   status_o,
  output logic                                cell_valid_o,
  output logic [glcw_pkg::IDX_W-1:0]          cell_index_o,
  output logic                                last_o
);

  import glcw_pkg::*;

  localparam int unsigned ONE_W   = FRAC_BITS + 1;
  localparam int unsigned PROD_W  = FRAC_BITS + COORD_W + 1;
  localparam int unsigned SCALE_W = FRAC_BITS + COORD_W;
  localparam int unsigned ERR_W   = FRAC_BITS + COORD_W + 2;
  localparam int unsigned N_W     = UNIT_BITS + 3;
  localparam int unsigned CM_W    = UNIT_BITS + COLS_W;
  localparam int unsigned CS_W    = UNIT_BITS + COLS_W + 1;

  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

  // endpoints
  logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  // products and step setup
  logic [PROD_W-1:0]  px_q, py_q;
  logic [COORD_W-1:0] dx_q, dy_q;
  logic               xpos_q, ypos_q, inf_pos_q, inf_neg_q;
  // walk state
  logic [UNIT_BITS-1:0]    walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic signed [ERR_W-1:0] step_error_q, step_error_d;
  logic signed [N_W-1:0]   squares_left_q, squares_left_d;
  logic [IDX_W-1:0]        previous_cell_q, previous_cell_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [COLS_W-1:0]       cols_q;
  // result register
  logic                    cell_valid_q, cell_valid_d;
  logic [IDX_W-1:0]        cell_index_q, cell_index_d;
  logic                    last_q, last_d;

  // setup terms
  logic [COORD_W-1:0] dx_c, dy_c, shx0, shy0, shx1, shy1;
  logic [FRAC_BITS-1:0] fx, fy;
  logic [ONE_W-1:0] xterm, yterm;
  logic [UNIT_BITS-1:0] ux0, uy0, ux1, uy1;
  logic signed [N_W-1:0] dux, duy;

  // walk terms
  logic [UNIT_BITS-1:0] cx, cy;
  logic [CM_W-1:0]      row_base;
  logic [CS_W-1:0]      cell_sum;
  logic [IDX_W-1:0]     cur_cell;
  logic                 new_cell, step_y, empty, capped;
  logic signed [ERR_W-1:0] dx_scaled, dy_scaled;

  assign dx_c = (ex_q > sx_q) ? ex_q - sx_q : sx_q - ex_q;
  assign dy_c = (ey_q > sy_q) ? ey_q - sy_q : sy_q - ey_q;
  assign fx   = sx_q[FRAC_BITS-1:0];
  assign fy   = sy_q[FRAC_BITS-1:0];
  assign xterm = (ex_q > sx_q) ? ONE - ONE_W'(fx) : ONE_W'(fx);
  assign yterm = (ey_q > sy_q) ? ONE - ONE_W'(fy) : ONE_W'(fy);

  assign shx0 = sx_q >> FRAC_BITS;
  assign shy0 = sy_q >> FRAC_BITS;
  assign shx1 = ex_q >> FRAC_BITS;
  assign shy1 = ey_q >> FRAC_BITS;
  assign ux0  = shx0[UNIT_BITS-1:0];
  assign uy0  = shy0[UNIT_BITS-1:0];
  assign ux1  = shx1[UNIT_BITS-1:0];
  assign uy1  = shy1[UNIT_BITS-1:0];

  // square count terms; zero when the axis does not move
  assign dux = xpos_q ? $signed(N_W'(ux1)) - $signed(N_W'(ux0))
                      : $signed(N_W'(ux0)) - $signed(N_W'(ux1));
  assign duy = ypos_q ? $signed(N_W'(uy1)) - $signed(N_W'(uy0))
                      : $signed(N_W'(uy0)) - $signed(N_W'(uy1));

  // cell index of the current square
  assign cx       = walk_x_q >> CELL_SHIFT;
  assign cy       = walk_y_q >> CELL_SHIFT;
  assign row_base = CM_W'(cy) * CM_W'(cols_q);
  assign cell_sum = CS_W'(cx) + CS_W'(row_base);
  assign cur_cell = cell_sum[IDX_W-1:0];

  assign empty    = (squares_left_q <= $signed(N_W'(0)));
  assign new_cell = (cnt_q == '0) || (cur_cell != previous_cell_q);
  assign capped   = !empty && new_cell && (cnt_q == MAX_RESULTS);
  assign step_y   = inf_pos_q || (!inf_neg_q && (step_error_q > $signed(ERR_W'(0))));

  assign dx_scaled = $signed(ERR_W'({dx_q, {FRAC_BITS{1'b0}}}));
  assign dy_scaled = $signed(ERR_W'({dy_q, {FRAC_BITS{1'b0}}}));

  assign status_o.empty      = empty;
  assign status_o.capped     = capped;
  assign status_o.final_step = (squares_left_q == $signed(N_W'(1)));

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
    end else if (cfg_we_i) begin
      cols_q <= cfg_wdata_i;
    end
  end

  // request capture and setup products
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
    if (cmd_i.mul) begin
      px_q      <= PROD_W'(xterm) * PROD_W'(dy_c);
      py_q      <= PROD_W'(yterm) * PROD_W'(dx_c);
      dx_q      <= dx_c;
      dy_q      <= dy_c;
      xpos_q    <= (ex_q > sx_q);
      ypos_q    <= (ey_q > sy_q);
      inf_neg_q <= (dy_c == '0);
      inf_pos_q <= (dx_c == '0) && (dy_c != '0);
    end
  end

  // walk step
  always_comb begin
    walk_x_d        = walk_x_q;
    walk_y_d        = walk_y_q;
    step_error_d    = step_error_q;
    squares_left_d  = squares_left_q;
    previous_cell_d = previous_cell_q;
    cnt_d           = cnt_q;
    cell_valid_d    = 1'b0;
    cell_index_d    = cell_index_q;
    last_d          = last_q;

    if (cmd_i.init) begin
      walk_x_d       = ux0;
      walk_y_d       = uy0;
      step_error_d   = $signed(ERR_W'(px_q)) - $signed(ERR_W'(py_q));
      squares_left_d = $signed(N_W'(1)) + dux + duy;
      cnt_d          = '0;
    end else if (cmd_i.walk && !empty) begin
      if (capped) begin
        // no room for another cell: close the segment on the held one
        cell_valid_d   = 1'b1;
        cell_index_d   = previous_cell_q;
        last_d         = 1'b1;
        squares_left_d = '0;
      end else begin
        if (new_cell) begin
          if (cnt_q != '0) begin
            cell_valid_d = 1'b1;
            cell_index_d = previous_cell_q;
            last_d       = 1'b0;
          end
          previous_cell_d = cur_cell;
          cnt_d           = cnt_q + CNT_W'(1);
        end
        if (step_y) begin
          walk_y_d = ypos_q ? walk_y_q + UNIT_BITS'(1) : walk_y_q - UNIT_BITS'(1);
          if (!inf_pos_q) begin
            step_error_d = step_error_q - dx_scaled;
          end
        end else begin
          walk_x_d = xpos_q ? walk_x_q + UNIT_BITS'(1) : walk_x_q - UNIT_BITS'(1);
          if (!inf_neg_q) begin
            step_error_d = step_error_q + dy_scaled;
          end
        end
        squares_left_d = squares_left_q - $signed(N_W'(1));
      end
    end else if (cmd_i.flush) begin
      cell_valid_d = 1'b1;
      cell_index_d = previous_cell_q;
      last_d       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q        <= '0;
      walk_y_q        <= '0;
      step_error_q    <= '0;
      squares_left_q  <= '0;
      previous_cell_q <= '0;
      cnt_q           <= '0;
      cell_valid_q    <= 1'b0;
    end else begin
      walk_x_q        <= walk_x_d;
      walk_y_q        <= walk_y_d;
      step_error_q    <= step_error_d;
      squares_left_q  <= squares_left_d;
      previous_cell_q <= previous_cell_d;
      cnt_q           <= cnt_d;
      cell_valid_q    <= cell_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_index_q <= cell_index_d;
    last_q       <= last_d;
  end

  assign cell_valid_o = cell_valid_q;
  assign cell_index_o = cell_index_q;
  assign last_o       = last_q;

endmodule

`default_nettype wire

[rtl/core/grid_line_cell_walk_core.sv]
// ----------------------------------------------------------------------------
// grid_line_cell_walk_core
// lists the grid cells crossed by one line segment with fixed-point endpoints
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o is low. The core then
// walks every unit square the segment crosses, 1 + |dux| + |duy| squares,
// one square per clock, and puts out the cell index of each run of equal
// cells once. Each result sits on cell_index_o / last_o for exactly one cycle
// with cell_valid_o high; the receiver cannot stall the core, so it must take
// every strobe. last_o marks the final cell of the segment, and at most 64
// cells are reported per segment (the 64th then carries last_o). Sequence:
// the core stays busy through the multiply state, the init state, the walk
// loop over the squares and the flush state; the 64-cell cap ends the walk
// early and skips the flush. A segment whose square count comes out empty
// after coordinate wrap yields no result. The last result strobes in the
// first cycle with busy_o low, so the next request may be taken at the edge
// that ends that strobe. The user must write columns_in_use through
// cfg_we_i / cfg_wdata_i only while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_line_cell_walk_core #(
  parameter int unsigned CELL_SHIFT = 3,
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned UNIT_BITS  = 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          cfg_we_i,
  input  wire logic [glcw_pkg::COLS_W-1:0]   cfg_wdata_i,
  // request
  input  wire logic                          start_i,
  output logic                               busy_o,
  input  wire logic [glcw_pkg::COORD_W-1:0]  start_x_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]  start_y_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]  end_x_i,
  input  wire logic [glcw_pkg::COORD_W-1:0]  end_y_i,
  // results
  output logic                               cell_valid_o,
  output logic [glcw_pkg::IDX_W-1:0]         cell_index_o,
  output logic                               last_o
);

  import glcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one state per phase, walk state loops per square
  glcw_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // error term, position, cell index and run folding
  glcw_datapath #(
    .CELL_SHIFT (CELL_SHIFT),
    .FRAC_BITS  (FRAC_BITS),
    .UNIT_BITS  (UNIT_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .status_o     (status),
    .cell_valid_o (cell_valid_o),
    .cell_index_o (cell_index_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the grid line cell walk core against its own cell-walk predictor
// ----------------------------------------------------------------------------
// Segments are queued by the stimulus process and presented by a driver at
// the falling edge. A monitor at the rising edge logs each accepted request,
// works out the cells it must produce, and compares every cell strobe with
// the oldest expected cell. The column count is changed between phases while
// the core is idle, and the sender idles at different rates per phase.
// ----------------------------------------------------------------------------

module testbench;

  import glcw_pkg::*;

  // block parameters, shared by the instance and the predictor, and bench limits
  localparam int CELL_SHIFT  = 3;
  localparam int FRAC_BITS   = 8;
  localparam int UNIT_BITS   = 8;
  localparam longint ONE     = longint'(1) << FRAC_BITS;
  localparam longint FMASK   = ONE - 1;
  localparam int UMASK       = (1 << UNIT_BITS) - 1;
  localparam int DRAIN_GUARD = 4000;
  localparam int MAX_LINES   = 50;

  // how the walk is steered for one segment
  typedef enum int {STEER_ERROR, STEER_Y_ONLY, STEER_X_ONLY} steer_e;

  typedef struct {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
    logic               hold_for_drain;
  } seg_t;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             last;
  } cell_res_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [COLS_W-1:0]  cfg_wdata_i;
  logic               start_i;
  logic               busy_o;
  logic [COORD_W-1:0] start_x_i;
  logic [COORD_W-1:0] start_y_i;
  logic [COORD_W-1:0] end_x_i;
  logic [COORD_W-1:0] end_y_i;
  logic               cell_valid_o;
  logic [IDX_W-1:0]   cell_index_o;
  logic               last_o;

  seg_t        segments_queued[$];
  cell_res_t   cells_due[$];
  logic [COLS_W-1:0] grid_cols;
  logic        req_taken;
  int          send_idle_pct;
  int          segments_taken;
  int          cells_checked;
  int          col_writes;
  int          mismatches;

  grid_line_cell_walk_core #(
    .CELL_SHIFT(CELL_SHIFT),
    .FRAC_BITS (FRAC_BITS),
    .UNIT_BITS (UNIT_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .start_x_i   (start_x_i),
    .start_y_i   (start_y_i),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .cell_valid_o(cell_valid_o),
    .cell_index_o(cell_index_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // hard stop in case the core hangs or drops a request
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    if (mismatches < MAX_LINES) begin
      $display("mismatch at %0t ns: %s expected %0d got %0d", $time, what, want_v, got_v);
    end
    mismatches++;
  endtask

  // cell list of one segment, folded the same way the core folds runs
  task automatic predict_cells(input logic [COORD_W-1:0] sx_v, input logic [COORD_W-1:0] sy_v,
                               input logic [COORD_W-1:0] ex_v, input logic [COORD_W-1:0] ey_v);
    longint sx, sy, ex, ey, dx, dy, err, n;
    int ux0, uy0, ux1, uy1, xi, yi, wx, wy, emitted;
    steer_e steer;
    logic [IDX_W-1:0] c, held;
    cell_res_t r;
    sx = longint'(sx_v);
    sy = longint'(sy_v);
    ex = longint'(ex_v);
    ey = longint'(ey_v);
    dx = (ex > sx) ? ex - sx : sx - ex;
    dy = (ey > sy) ? ey - sy : sy - ey;
    ux0 = int'(sx >> FRAC_BITS) & UMASK;
    uy0 = int'(sy >> FRAC_BITS) & UMASK;
    ux1 = int'(ex >> FRAC_BITS) & UMASK;
    uy1 = int'(ey >> FRAC_BITS) & UMASK;
    n = 1;
    err = 0;
    xi = 0;
    yi = 0;
    emitted = 0;
    held = '0;
    steer = STEER_ERROR;
    // error starts as (distance to next x line) * dy - (distance to next y line) * dx
    if (dx == 0) begin
      steer = STEER_Y_ONLY;
    end else if (ex > sx) begin
      xi = 1;
      n += ux1 - ux0;
      err = (ONE - (sx & FMASK)) * dy;
    end else begin
      xi = -1;
      n += ux0 - ux1;
      err = (sx & FMASK) * dy;
    end
    // a flat segment (and a single point) only ever steps in x
    if (dy == 0) begin
      steer = STEER_X_ONLY;
    end else if (ey > sy) begin
      yi = 1;
      n += uy1 - uy0;
      err -= (ONE - (sy & FMASK)) * dx;
    end else begin
      yi = -1;
      n += uy0 - uy1;
      err -= (sy & FMASK) * dx;
    end
    wx = ux0;
    wy = uy0;
    while (n > 0) begin
      c = IDX_W'((wx >> CELL_SHIFT) + (wy >> CELL_SHIFT) * int'(grid_cols));
      if (emitted == 0 || c != held) begin
        if (emitted >= int'(MAX_RESULTS)) break;
        if (emitted > 0) begin
          r.idx  = held;
          r.last = 1'b0;
          cells_due.push_back(r);
        end
        held = c;
        emitted++;
      end
      if (steer == STEER_Y_ONLY || (steer == STEER_ERROR && err > 0)) begin
        wy = (wy + yi) & UMASK;
        if (steer == STEER_ERROR) err -= dx * ONE;
      end else begin
        wx = (wx + xi) & UMASK;
        if (steer == STEER_ERROR) err += dy * ONE;
      end
      n--;
    end
    // held cell is the final one of the segment
    if (emitted > 0) begin
      r.idx  = held;
      r.last = 1'b1;
      cells_due.push_back(r);
    end
  endtask

  // monitor: check strobes first, then log a request taken at this edge
  always @(posedge clk_i) begin : watch
    cell_res_t want;
    if (rst_ni) begin
      if (cell_valid_o) begin
        if (cells_due.size() == 0) begin
          report_mismatch("cell with nothing expected, index", -1, int'(cell_index_o));
        end else begin
          want = cells_due.pop_front();
          if (cell_index_o !== want.idx)
            report_mismatch("cell_index", int'(want.idx), int'(cell_index_o));
          if (last_o !== want.last)
            report_mismatch("last", int'(want.last), int'(last_o));
          cells_checked++;
        end
      end
      if (start_i && !busy_o) begin
        predict_cells(start_x_i, start_y_i, end_x_i, end_y_i);
        segments_taken++;
      end
      req_taken <= start_i && !busy_o;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // driver: start stays up until the request is taken, gaps only between requests
  always @(negedge clk_i) begin : drive
    seg_t nxt;
    logic go;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      start_x_i <= '0;
      start_y_i <= '0;
      end_x_i   <= '0;
      end_y_i   <= '0;
    end else if (!start_i || req_taken) begin
      go = segments_queued.size() != 0;
      if (go && segments_queued[0].hold_for_drain && cells_due.size() != 0) go = 1'b0;
      if (go && $urandom_range(0, 99) < send_idle_pct) go = 1'b0;
      if (go) begin
        nxt = segments_queued.pop_front();
        start_x_i <= nxt.x0;
        start_y_i <= nxt.y0;
        end_x_i   <= nxt.x1;
        end_y_i   <= nxt.y1;
      end
      start_i <= go;
    end
  end

  task automatic add_segment(input int x0, input int y0, input int x1, input int y1,
                             input logic drain);
    seg_t s;
    s.x0 = COORD_W'(x0);
    s.y0 = COORD_W'(y0);
    s.x1 = COORD_W'(x1);
    s.y1 = COORD_W'(y1);
    s.hold_for_drain = drain;
    segments_queued.push_back(s);
  endtask

  // random point near base, clamped to the coordinate range
  function automatic int nudge(input int base, input int span);
    int v;
    v = base + int'($urandom_range(0, 2 * span)) - span;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  // mostly short segments with random fractions; some long, flat, upright or tiny
  task automatic add_random_segment();
    int kind, span, x0, y0, x1, y1;
    kind = $urandom_range(0, 9);
    span = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) * 256 : $urandom_range(1, 8) * 256;
    x0 = int'($urandom_range(0, 65535));
    y0 = int'($urandom_range(0, 65535));
    case (kind)
      0: begin
        x1 = int'($urandom_range(0, 65535));
        y1 = int'($urandom_range(0, 65535));
      end
      1: begin
        x1 = x0;
        y1 = nudge(y0, span);
      end
      2: begin
        x1 = nudge(x0, span);
        y1 = y0;
      end
      3: begin
        x1 = ($urandom_range(0, 1) == 0) ? x0 : nudge(x0, 96);
        y1 = ($urandom_range(0, 1) == 0) ? y0 : nudge(y0, 96);
      end
      default: begin
        x1 = nudge(x0, span);
        y1 = nudge(y0, span);
      end
    endcase
    add_segment(x0, y0, x1, y1, $urandom_range(0, 19) == 0);
  endtask

  task automatic write_columns(input logic [COLS_W-1:0] cols);
    @(negedge clk_i);
    cfg_wdata_i <= cols;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    grid_cols = cols;
    col_writes++;
  endtask

  // wait for every queued request to go out and every expected cell to come back
  task automatic settle();
    int guard;
    guard = 0;
    // start_i and the queue are stable at the rising edge
    while (segments_queued.size() != 0 || start_i) @(posedge clk_i);
    @(negedge clk_i);
    while (cells_due.size() != 0 && guard < DRAIN_GUARD) begin
      @(negedge clk_i);
      guard++;
    end
    if (cells_due.size() != 0) begin
      report_mismatch("cells never reported, count", 0, cells_due.size());
      cells_due.delete();
    end
    while (busy_o) @(negedge clk_i);
    // trailing cycles in case anything still comes out
    repeat (8) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int phase_cols[6];
    int phase_idle[6];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    send_idle_pct = 0;
    grid_cols     = COLS_RESET;
    segments_taken = 0;
    cells_checked  = 0;
    col_writes     = 0;
    mismatches     = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed segments at the reset column count
    add_segment(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0); // point at origin
    add_segment(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0); // point at far corner
    add_segment(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0); // whole diagonal
    add_segment(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b0); // same, reversed
    add_segment(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b0); // anti-diagonal
    add_segment(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1); // after a full drain
    add_segment(16'h1234, 16'h0000, 16'h1234, 16'hFFFF, 1'b0); // upright, full height
    add_segment(16'h0000, 16'hABCD, 16'hFFFF, 16'hABCD, 1'b0); // flat, full width
    add_segment(16'h0100, 16'h0100, 16'h0500, 16'h0500, 1'b0); // passes through corners
    add_segment(16'h05FF, 16'h0300, 16'h0301, 16'h0700, 1'b0); // fraction extremes
    add_segment(16'h0080, 16'h00FF, 16'h0001, 16'h0000, 1'b0); // inside one square
    add_segment(16'h0700, 16'h0700, 16'h0800, 16'h0700, 1'b0); // flat over a cell line
    add_segment(16'h0800, 16'h07FF, 16'h0800, 16'h0801, 1'b0); // upright over a cell line
    add_segment(16'h5A5A, 16'hA5A5, 16'hA5A5, 16'h5A5A, 1'b0);
    add_segment(16'hFF00, 16'h00FF, 16'h00FF, 16'hFF00, 1'b0);
    add_segment(16'h3F80, 16'h1FFF, 16'h4001, 16'h2001, 1'b0);
    settle();

    // column count and sender idle rate per random phase
    phase_cols = '{1, 63, 0, int'($urandom_range(2, 62)), 32, int'($urandom_range(2, 62))};
    phase_idle = '{0, 86, 14, 0, 86, 14};
    for (int p = 0; p < 6; p++) begin
      write_columns(COLS_W'(phase_cols[p]));
      send_idle_pct = phase_idle[p];
      for (int i = 0; i < 80; i++) add_random_segment();
      settle();
    end

    $display("covered %0d segments and %0d checked cells under %0d column writes",
             segments_taken, cells_checked, col_writes);
    $display("column counts from 0 to 63, sender idle rates of 0, 14 and 86 percent");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/glcw_pkg.sv
rtl/core/glcw_ctrl.sv
rtl/core/glcw_datapath.sv
rtl/core/grid_line_cell_walk_core.sv
test/testbench.sv
